FILE: design/pcc_pkg.sv
// Package for the photon cross correlator.
// Shared item type, event kinds, register indexes and a saturating add helper.
// No dependencies.
package pcc_pkg;

  typedef enum logic [1:0] {
    K_PHOTON = 2'd0,
    K_START  = 2'd1,
    K_END    = 2'd2,
    K_READ   = 2'd3
  } kind_e;

  localparam logic [1:0] REG_SAMPLE_TIME = 2'd0;
  localparam logic [1:0] REG_FIRST_LAG   = 2'd1;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] time_gap;
    logic        in_a;
    logic        in_b;
    logic [5:0]  lag_index;
  } item_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] v, input logic inc);
    logic [16:0] s;
    s = {1'b0, v} + {16'd0, inc};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

FILE: design/photon_cross_correlator.sv
// Photon cross correlator, top level.
// Input queue, then a front end that queues events for the back end that bins them,
// updates the delay line and lag accumulators and answers reads.
// Result: one item per read event, held on the result ports while empty is low,
// taken with pop. Other event kinds give no result.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 sample_time, 1 first_lag_bins) in the same cycle; write only while idle.
// Per item: a photon inside its bin only updates the bin state; a bin close
// with a nonzero A count makes a one-lag-per-cycle accumulator pass over the
// single accumulator port, and skips it otherwise. A gap past the bin end adds
// a bit-serial division, plus one close per skipped bin, or a wipe of the delay
// line for very long gaps. A line start on a dirty chain also wipes the delay line.
// A read goes through S_READ and S_PUSH to the result register, and waits in
// S_PUSH while the previous result is still held.
// Reset: a clearing pass zeroes both memories; full stays high until it ends.
// A stalled receiver holds the result; up to four events still queue in front.
// Depends on pcc_pkg, pcc_front, pcc_back.
module photon_cross_correlator #(
  parameter int NUM_LAGS       = 64,
  parameter int MAX_DELAY_BINS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [31:0] time_gap_i,
  input  logic        in_a_i,
  input  logic        in_b_i,
  input  logic [5:0]  lag_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [47:0] lag_sum_o,
  output logic [47:0] total_a_o,
  output logic [47:0] total_b_o,
  output logic [47:0] total_bins_o,
  output logic [31:0] clear_count_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);
  import pcc_pkg::*;

  item_t item;
  logic  item_valid, item_pop, init_busy, out_valid;

  pcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .time_gap_i   (time_gap_i),
    .in_a_i       (in_a_i),
    .in_b_i       (in_b_i),
    .lag_index_i  (lag_index_i),
    .init_busy_i  (init_busy),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  pcc_back #(
    .NUM_LAGS       (NUM_LAGS),
    .MAX_DELAY_BINS (MAX_DELAY_BINS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .init_busy_o   (init_busy),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid),
    .out_pop_i     (pop && out_valid),
    .lag_sum_o     (lag_sum_o),
    .total_a_o     (total_a_o),
    .total_b_o     (total_b_o),
    .total_bins_o  (total_bins_o),
    .clear_count_o (clear_count_o)
  );

  assign empty = !out_valid;

endmodule

FILE: design/pcc_front.sv
// Front end of the photon cross correlator: accepts and classifies items
// and holds them in a short queue for the back end. Depends on pcc_pkg.
module pcc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [1:0]     kind_i,
  input  logic [31:0]    time_gap_i,
  input  logic           in_a_i,
  input  logic           in_b_i,
  input  logic [5:0]     lag_index_i,
  input  logic           init_busy_i,
  output logic           item_valid_o,
  output pcc_pkg::item_t item_o,
  input  logic           item_pop_i
);
  import pcc_pkg::*;

  item_t       fifo_q [4];
  logic [1:0]  wr_q, rd_q;
  logic [2:0]  cnt_q;
  logic        wr_en, rd_en;
  item_t       item_in;

  assign full         = (cnt_q == 3'd4) || init_busy_i;
  assign wr_en        = push && !full;
  assign rd_en        = item_pop_i && (cnt_q != 3'd0);
  assign item_valid_o = (cnt_q != 3'd0);
  assign item_o       = fifo_q[rd_q];

  always_comb begin
    item_in.kind      = kind_e'(kind_i);
    item_in.time_gap  = time_gap_i;
    item_in.in_a      = in_a_i;
    item_in.in_b      = in_b_i;
    item_in.lag_index = lag_index_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 2'd1;
      if (rd_en) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

endmodule

FILE: design/pcc_div.sv
// Bit-serial restoring divider, 32-bit dividend by 24-bit divisor,
// one quotient bit per cycle. No dependencies.
module pcc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [23:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [23:0] rem_o
);
  logic [31:0] q_q;
  logic [23:0] r_q, d_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [24:0] trial;

  assign trial  = {r_q, q_q[31]};
  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        q_q    <= dividend_i;
        r_q    <= '0;
        d_q    <= divisor_i;
      end else if (busy_q) begin
        // dividend bits shift out of the top while quotient bits fill the bottom
        if (trial >= {1'b0, d_q}) begin
          r_q <= 24'(trial - {1'b0, d_q});
          q_q <= {q_q[30:0], 1'b1};
        end else begin
          r_q <= trial[23:0];
          q_q <= {q_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/pcc_back.sv
// Back end of the photon cross correlator: bin state, delay line and lag
// accumulator memories, the bin-close sequencer and readout.
// Depends on pcc_pkg and pcc_div.
module pcc_back #(
  parameter int NUM_LAGS       = 64,
  parameter int MAX_DELAY_BINS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  pcc_pkg::item_t item_i,
  output logic           item_pop_o,
  output logic           init_busy_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [23:0]    cfg_wdata_i,
  output logic           out_valid_o,
  input  logic           out_pop_i,
  output logic [47:0]    lag_sum_o,
  output logic [47:0]    total_a_o,
  output logic [47:0]    total_b_o,
  output logic [47:0]    total_bins_o,
  output logic [31:0]    clear_count_o
);
  import pcc_pkg::*;

  localparam int LD = NUM_LAGS + MAX_DELAY_BINS;
  localparam int AW = (LD > 1) ? $clog2(LD) : 1;
  localparam int CW = $clog2(LD + 1);
  localparam int KW = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_READ, S_PUSH, S_CB_MOD, S_CB_WR, S_CB_LAG, S_CB_DRAIN,
    S_CB_FIN, S_DIV, S_DIVDONE, S_PH_TAIL, S_LONG, S_LONG_WR
  } state_e;

  typedef enum logic [1:0] {R_IDLE, R_DIV_PH, R_DIV_LE, R_ZLOOP} ret_e;

  state_e      state_q;
  ret_e        ret_q;
  item_t       it_q;
  logic [23:0] st_q;
  logic [6:0]  flb_q;
  logic [AW-1:0] wp_q, idx_q, sw_q;
  logic [KW-1:0] k_q, k1_q, k2_q;
  logic [CW-1:0] cnt_q;
  logic [15:0] bca_q, bcb_q;
  logic [23:0] rem_q;
  logic [47:0] suma_q, sumb_q, bins_q;
  logic [31:0] clears_q, gap_q;
  logic        clean_q, acc_clr_q, sw_long_q;
  logic        out_v_q;
  logic [47:0] o_lag_q, o_a_q, o_b_q, o_bins_q;
  logic [31:0] o_clr_q;

  // lag pipeline
  logic        v1_q, v2_q;
  logic [31:0] prod_q;
  logic [47:0] accp_q;

  logic [15:0] dl_mem [LD];
  logic [47:0] acc_mem [NUM_LAGS];
  logic [15:0] dl_rd_q;
  logic [47:0] acc_rd_q;
  logic          dl_we, acc_we, lag_issue;
  logic [AW-1:0] dl_wa, dl_ra, wpn, idx0;
  logic [15:0]   dl_wd;
  logic [KW-1:0] acc_wa, acc_ra;
  logic [47:0]   acc_wd;

  logic [CW-1:0] off, len;
  logic [CW:0]   ssum;
  logic [32:0]   gap_in;
  logic          div_start, div_done;
  logic [31:0]   div_dvd, div_q;
  logic [23:0]   div_r;
  logic          tail_full;

  always_comb begin
    if (32'(flb_q) < MAX_DELAY_BINS) off = CW'(flb_q);
    else                             off = CW'(MAX_DELAY_BINS);
    len = CW'(NUM_LAGS) + off;
    wpn = (wp_q == '0) ? AW'(len - CW'(1)) : AW'(wp_q - AW'(1));
    ssum = (CW+1)'(wpn) + (CW+1)'(off);
    idx0 = (ssum >= (CW+1)'(len)) ? AW'(ssum - (CW+1)'(len)) : AW'(ssum);
  end

  assign tail_full   = (div_r == st_q - 24'd1);
  assign init_busy_o = (state_q == S_SWEEP) && acc_clr_q;
  assign item_pop_o  = (state_q == S_IDLE) && item_valid_i;
  assign lag_issue   = (state_q == S_CB_LAG);
  assign gap_in      = {1'b0, item_i.time_gap};

  assign div_start = (state_q == S_CB_FIN) && (ret_q == R_DIV_PH || ret_q == R_DIV_LE);
  assign div_dvd   = (ret_q == R_DIV_PH) ? gap_q - 32'd1 : gap_q;

  pcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (st_q),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_comb begin
    dl_we  = 1'b0;
    dl_wa  = wp_q;
    dl_wd  = '0;
    dl_ra  = idx_q;
    acc_we = v2_q;
    acc_wa = k2_q;
    acc_wd = accp_q + 48'(prod_q);
    acc_ra = KW'(it_q.lag_index);
    unique case (state_q)
      S_SWEEP: begin
        dl_we = 1'b1;
        dl_wa = sw_q;
        if (acc_clr_q && (32'(sw_q) < NUM_LAGS)) begin
          acc_we = 1'b1;
          acc_wa = KW'(sw_q);
          acc_wd = '0;
        end
      end
      S_CB_WR: begin
        dl_we = 1'b1;
        dl_wa = wpn;
        dl_wd = bcb_q;
      end
      S_CB_LAG: acc_ra = k_q;
      S_LONG: begin
        acc_ra = '0;
        if (tail_full) begin
          dl_we = 1'b1;
          dl_wa = '0;
          dl_wd = {15'd0, it_q.in_b};
        end
      end
      S_LONG_WR: begin
        if (flb_q == 7'd0) begin
          acc_we = 1'b1;
          acc_wa = '0;
          acc_wd = acc_rd_q + {47'd0, it_q.in_a & it_q.in_b};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) dl_mem[dl_wa] <= dl_wd;
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    dl_rd_q  <= dl_mem[dl_ra];
    acc_rd_q <= acc_mem[acc_ra];
    k1_q     <= k_q;
    k2_q     <= k1_q;
    prod_q   <= 32'(dl_rd_q) * 32'(bca_q);
    accp_q   <= acc_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= lag_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= 24'd1;
      flb_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SAMPLE_TIME) begin
        st_q <= (cfg_wdata_i == '0) ? 24'd1 : cfg_wdata_i;
      end else if (cfg_idx_i == REG_FIRST_LAG) begin
        flb_q <= cfg_wdata_i[6:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SWEEP;
      ret_q     <= R_IDLE;
      it_q      <= '0;
      wp_q      <= '0;
      idx_q     <= '0;
      sw_q      <= '0;
      k_q       <= '0;
      cnt_q     <= '0;
      bca_q     <= '0;
      bcb_q     <= '0;
      rem_q     <= 24'd1;
      suma_q    <= '0;
      sumb_q    <= '0;
      bins_q    <= '0;
      clears_q  <= 32'd1;
      gap_q     <= '0;
      clean_q   <= 1'b1;
      acc_clr_q <= 1'b1;
      sw_long_q <= 1'b0;
      out_v_q   <= 1'b0;
      o_lag_q   <= '0;
      o_a_q     <= '0;
      o_b_q     <= '0;
      o_bins_q  <= '0;
      o_clr_q   <= '0;
    end else begin
      if (out_pop_i) out_v_q <= 1'b0;
      unique case (state_q)
        S_SWEEP: begin
          sw_q <= sw_q + AW'(1);
          if (sw_q == AW'(LD - 1)) begin
            sw_q      <= '0;
            acc_clr_q <= 1'b0;
            state_q   <= sw_long_q ? S_LONG : S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid_i) begin
            it_q <= item_i;
            unique case (item_i.kind)
              K_PHOTON: begin
                clean_q <= 1'b0;
                if (gap_in < 33'(rem_q)) begin
                  rem_q   <= rem_q - item_i.time_gap[23:0];
                  bca_q   <= sat_add16(bca_q, item_i.in_a);
                  bcb_q   <= sat_add16(bcb_q, item_i.in_b);
                end else if (gap_in == 33'(rem_q)) begin
                  bca_q   <= sat_add16(bca_q, item_i.in_a);
                  bcb_q   <= sat_add16(bcb_q, item_i.in_b);
                  ret_q   <= R_IDLE;
                  state_q <= S_CB_MOD;
                end else begin
                  gap_q   <= item_i.time_gap - 32'(rem_q);
                  ret_q   <= R_DIV_PH;
                  state_q <= S_CB_MOD;
                end
              end
              K_START: begin
                if (!clean_q) begin
                  bca_q     <= '0;
                  bcb_q     <= '0;
                  rem_q     <= st_q;
                  clean_q   <= 1'b1;
                  clears_q  <= clears_q + 32'd1;
                  wp_q      <= '0;
                  sw_long_q <= 1'b0;
                  state_q   <= S_SWEEP;
                end
              end
              K_END: begin
                if (gap_in >= 33'(rem_q)) begin
                  gap_q   <= item_i.time_gap - 32'(rem_q);
                  ret_q   <= R_DIV_LE;
                  state_q <= S_CB_MOD;
                end
              end
              K_READ: state_q <= S_READ;
              default: ;
            endcase
          end
        end
        S_READ: state_q <= S_PUSH;
        S_PUSH: begin
          if (!out_v_q || out_pop_i) begin
            out_v_q  <= 1'b1;
            o_lag_q  <= (32'(it_q.lag_index) < NUM_LAGS) ? acc_rd_q : '0;
            o_a_q    <= suma_q;
            o_b_q    <= sumb_q;
            o_bins_q <= bins_q;
            o_clr_q  <= clears_q;
            state_q  <= S_IDLE;
          end
        end
        S_CB_MOD: begin
          // line length may have shrunk since the last write
          if (CW'(wp_q) >= len) wp_q <= wp_q - AW'(len);
          else                  state_q <= S_CB_WR;
        end
        S_CB_WR: begin
          wp_q    <= wpn;
          idx_q   <= idx0;
          k_q     <= '0;
          state_q <= (bca_q == '0) ? S_CB_FIN : S_CB_LAG;
        end
        S_CB_LAG: begin
          idx_q <= (CW'(idx_q) + CW'(1) == len) ? '0 : idx_q + AW'(1);
          k_q   <= k_q + KW'(1);
          if (k_q == KW'(NUM_LAGS - 1)) state_q <= S_CB_DRAIN;
        end
        S_CB_DRAIN: begin
          if (!v1_q && !v2_q) state_q <= S_CB_FIN;
        end
        S_CB_FIN: begin
          rem_q  <= st_q;
          bins_q <= bins_q + 48'd1;
          suma_q <= suma_q + 48'(bca_q);
          sumb_q <= sumb_q + 48'(bcb_q);
          bca_q  <= '0;
          bcb_q  <= '0;
          unique case (ret_q)
            R_IDLE:   state_q <= S_IDLE;
            R_DIV_PH,
            R_DIV_LE: state_q <= S_DIV;
            R_ZLOOP: begin
              cnt_q   <= cnt_q - CW'(1);
              state_q <= (cnt_q == CW'(1)) ? S_PH_TAIL : S_CB_MOD;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (div_done) state_q <= S_DIVDONE;
        end
        S_DIVDONE: begin
          if (ret_q == R_DIV_LE) begin
            bins_q  <= bins_q + 48'(div_q);
            clean_q <= 1'b0;
            state_q <= S_IDLE;
          end else if (div_q <= 32'(len)) begin
            cnt_q <= div_q[CW-1:0];
            ret_q <= R_ZLOOP;
            state_q <= (div_q == '0) ? S_PH_TAIL : S_CB_MOD;
          end else begin
            // gap outruns the whole line: wipe it and count the skipped bins
            wp_q      <= '0;
            sw_long_q <= 1'b1;
            state_q   <= S_SWEEP;
          end
        end
        S_PH_TAIL: begin
          bca_q <= {15'd0, it_q.in_a};
          bcb_q <= {15'd0, it_q.in_b};
          if (tail_full) begin
            ret_q   <= R_IDLE;
            state_q <= S_CB_MOD;
          end else begin
            rem_q   <= st_q - 24'd1 - div_r;
            state_q <= S_IDLE;
          end
        end
        S_LONG: begin
          bins_q <= bins_q + 48'(div_q);
          if (tail_full) begin
            state_q <= S_LONG_WR;
          end else begin
            bca_q   <= {15'd0, it_q.in_a};
            bcb_q   <= {15'd0, it_q.in_b};
            rem_q   <= st_q - 24'd1 - div_r;
            state_q <= S_IDLE;
          end
        end
        S_LONG_WR: begin
          bins_q  <= bins_q + 48'd1;
          suma_q  <= suma_q + {47'd0, it_q.in_a};
          sumb_q  <= sumb_q + {47'd0, it_q.in_b};
          bca_q   <= '0;
          bcb_q   <= '0;
          rem_q   <= st_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_v_q;
  assign lag_sum_o     = o_lag_q;
  assign total_a_o     = o_a_q;
  assign total_b_o     = o_b_q;
  assign total_bins_o  = o_bins_q;
  assign clear_count_o = o_clr_q;

endmodule

FILE: design/pcc_checker.sv
// Port-level checks for the photon cross correlator and their bind.
// Depends on photon_cross_correlator.
module pcc_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [47:0] lag_sum_o,
  input logic [31:0] clear_count_o
);

  // memories are still being wiped right after reset
  a_init_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> full)
    else $error("input taken during clearing pass");

  a_init_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(lag_sum_o) && $stable(clear_count_o)))
    else $error("result changed while stalled");

endmodule

bind photon_cross_correlator pcc_port_checker u_pcc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .lag_sum_o     (lag_sum_o),
  .clear_count_o (clear_count_o)
);
